/* design/complex_divide_top_defines.svh */
// Assertion macros for the complex divider.
// Used by complex_divide_top; no other dependencies.
`ifndef COMPLEX_DIVIDE_TOP_DEFINES_SVH
`define COMPLEX_DIVIDE_TOP_DEFINES_SVH
`ifndef SYNTH
`define CD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define CD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CD_ASSERT_IMP(lbl, ante, cons, msg)
`define CD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* design/cdiv_pkg.sv */
// Shared types, constants and helpers of the complex divider.
// No dependencies.
package cdiv_pkg;

    localparam int CDIV_FRAC_BITS = 24;

    typedef struct packed {
        logic signed [31:0] dividend_re;
        logic signed [31:0] dividend_im;
        logic signed [31:0] divisor_re;
        logic signed [31:0] divisor_im;
    } cdiv_in_t;

    typedef struct packed {
        logic signed [31:0] quotient_re;
        logic signed [31:0] quotient_im;
        logic               divide_fault;
        logic               saturated;
        logic [31:0]        fault_total;
    } cdiv_out_t;

    // request to the shared divider
    typedef struct packed {
        logic        start;
        logic        neg;
        logic [63:0] num;
        logic [63:0] den;
    } cdiv_req_t;

    // answer from the shared divider
    typedef struct packed {
        logic        done;
        logic        sat;
        logic [31:0] quo;
    } cdiv_rsp_t;

    // two's complement to magnitude; -2^31 maps to 2^31
    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    // sign/magnitude add, result sign in bit 64
    function automatic logic [64:0] sm_add(input logic na, input logic [63:0] ma,
                                           input logic nb, input logic [63:0] mb);
        logic [64:0] r;
        if (na == nb) begin
            r = {na, ma + mb};
        end else if (ma >= mb) begin
            r = {na, ma - mb};
        end else begin
            r = {nb, mb - ma};
        end
        sm_add = r;
    endfunction

endpackage

/* design/cdiv_divider.sv */
// Shared radix-2 restoring divider: (num << FRAC_BITS) / den, 32-bit result,
// sign applied and saturated. Depends on cdiv_pkg.
module cdiv_divider import cdiv_pkg::*; #(
    parameter int FRAC_BITS = CDIV_FRAC_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cdiv_req_t req,
    output cdiv_rsp_t rsp
);

    localparam int NW = 64 + FRAC_BITS;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_FIN  = 3'b100
    } dstate_t;

    dstate_t     state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [64:0] rem_reg, rem_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] q_reg, q_next;
    logic [63:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic        ovf_reg, ovf_next;
    logic        done_reg, done_next;
    logic        sat_reg, sat_next;
    logic [31:0] quo_reg, quo_next;

    logic [NW-1:0] n_w;
    logic [64:0]   trial;
    logic [64:0]   diff;
    logic [31:0]   limit;
    logic          fin_sat;
    logic [31:0]   qm;

    assign n_w   = {req.num, {FRAC_BITS{1'b0}}};
    assign trial = {rem_reg[63:0], low_reg[31]};
    assign diff  = trial - {1'b0, den_reg};
    assign limit = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign fin_sat = ovf_reg | (q_reg > limit);
    assign qm    = fin_sat ? limit : q_reg;

    // sequence: load, 32 shift/subtract steps (skipped on overflow), then sign and clamp
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        q_next     = q_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        done_next  = 1'b0;
        sat_next   = sat_reg;
        quo_next   = quo_reg;
        case (state_reg)
            D_IDLE: begin
                if (req.start) begin
                    rem_next = 65'(n_w[NW-1:32]);
                    low_next = n_w[31:0];
                    den_next = req.den;
                    neg_next = req.neg;
                    q_next   = '0;
                    cnt_next = '0;
                    ovf_next = (65'(n_w[NW-1:32]) >= {1'b0, req.den});
                    state_next = (65'(n_w[NW-1:32]) >= {1'b0, req.den}) ? D_FIN : D_RUN;
                end
            end
            D_RUN: begin
                if (!diff[64]) begin
                    rem_next = diff;
                end else begin
                    rem_next = trial;
                end
                q_next   = {q_reg[30:0], ~diff[64]};
                low_next = {low_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = D_FIN;
                end
            end
            D_FIN: begin
                sat_next   = fin_sat;
                quo_next   = neg_reg ? (32'd0 - qm) : qm;
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
        sat_reg <= sat_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign rsp.quo  = quo_reg;

endmodule

/* design/complex_divide_top.sv */
// Channel   | Ports                     | Payload
// request   | s_valid s_ready s_data    | cdiv_in_t  (dividend, divisor)
// result    | m_valid m_ready m_data    | cdiv_out_t (quotient, flags, count)
// One request goes through the shared 32x32 multiplier, then the modulus and
// numerators are formed, then two passes go through the shared radix-2
// divider. A zero modulus skips the divider.
// s_ready is high only while idle; a result holds in m_data until taken.
// Reset (aresetn, synchronous) clears the sequencer and the fault counter.
// Depends on cdiv_pkg, cdiv_divider and complex_divide_top_defines.svh.
`include "complex_divide_top_defines.svh"
module complex_divide_top import cdiv_pkg::*; #(
    parameter int FRAC_BITS = CDIV_FRAC_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cdiv_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output cdiv_out_t m_data
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL    = 7'b0000010,
        S_SUM    = 7'b0000100,
        S_NUM    = 7'b0001000,
        S_DIV_RE = 7'b0010000,
        S_DIV_IM = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] xr_reg, xi_reg, yr_reg, yi_reg;
    logic        nxr_reg, nxi_reg, nyr_reg, nyi_reg;
    logic [63:0] prod_reg;
    logic [63:0] pr_reg [6];
    logic [63:0] mod_reg;
    logic [64:0] nre_reg, nim_reg;
    logic [31:0] fcnt_reg, fcnt_next;
    cdiv_out_t   out_reg, out_next;
    logic        start_reg, start_next;
    logic        sat_re_reg, sat_re_next;
    logic [31:0] q_re_reg, q_re_next;

    logic [31:0] op_a, op_b;
    logic [64:0] num_sum;
    cdiv_req_t   dreq;
    cdiv_rsp_t   drsp;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_DONE);
    assign m_data  = out_reg;

    // pick multiplier operands
    always_comb begin
        case (cnt_reg)
            3'd0:    begin op_a = yr_reg; op_b = yr_reg; end
            3'd1:    begin op_a = yi_reg; op_b = yi_reg; end
            3'd2:    begin op_a = xr_reg; op_b = yr_reg; end
            3'd3:    begin op_a = xi_reg; op_b = yi_reg; end
            3'd4:    begin op_a = xi_reg; op_b = yr_reg; end
            default: begin op_a = xr_reg; op_b = yi_reg; end
        endcase
    end

    // signed sum of the cross products for one numerator
    assign num_sum = (cnt_reg == 3'd0)
        ? sm_add(nxr_reg ^ nyr_reg, pr_reg[2], nxi_reg ^ nyi_reg, pr_reg[3])
        : sm_add(nxi_reg ^ nyr_reg, pr_reg[4], ~(nxr_reg ^ nyi_reg), pr_reg[5]);

    assign dreq.start = start_reg;
    assign dreq.neg   = (state_reg == S_DIV_IM) ? nim_reg[64] : nre_reg[64];
    assign dreq.num   = (state_reg == S_DIV_IM) ? nim_reg[63:0] : nre_reg[63:0];
    assign dreq.den   = mod_reg;

    cdiv_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    // sequencer
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        fcnt_next   = fcnt_reg;
        out_next    = out_reg;
        start_next  = 1'b0;
        sat_re_next = sat_re_reg;
        q_re_next   = q_re_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd6) begin
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                cnt_next   = '0;
                state_next = S_NUM;
            end
            S_NUM: begin
                cnt_next = cnt_reg + 3'd1;
                if (mod_reg == 64'd0) begin
                    // zero divisor: flag, zero result, bump the counter
                    if (fcnt_reg != 32'hFFFF_FFFF) begin
                        fcnt_next = fcnt_reg + 32'd1;
                    end
                    out_next.quotient_re  = '0;
                    out_next.quotient_im  = '0;
                    out_next.divide_fault = 1'b1;
                    out_next.saturated    = 1'b0;
                    out_next.fault_total  = fcnt_next;
                    state_next = S_DONE;
                end else if (cnt_reg == 3'd1) begin
                    start_next = 1'b1;
                    state_next = S_DIV_RE;
                end
            end
            S_DIV_RE: begin
                if (drsp.done) begin
                    q_re_next   = drsp.quo;
                    sat_re_next = drsp.sat;
                    start_next  = 1'b1;
                    state_next  = S_DIV_IM;
                end
            end
            S_DIV_IM: begin
                if (drsp.done) begin
                    out_next.quotient_re  = q_re_reg;
                    out_next.quotient_im  = drsp.quo;
                    out_next.divide_fault = 1'b0;
                    out_next.saturated    = sat_re_reg | drsp.sat;
                    out_next.fault_total  = fcnt_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fcnt_reg  <= '0;
            start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fcnt_reg  <= fcnt_next;
            start_reg <= start_next;
        end
        cnt_reg    <= cnt_next;
        out_reg    <= out_next;
        sat_re_reg <= sat_re_next;
        q_re_reg   <= q_re_next;
        // capture operands as magnitudes and signs
        if (s_valid && s_ready) begin
            xr_reg  <= mag32(s_data.dividend_re);
            xi_reg  <= mag32(s_data.dividend_im);
            yr_reg  <= mag32(s_data.divisor_re);
            yi_reg  <= mag32(s_data.divisor_im);
            nxr_reg <= s_data.dividend_re[31];
            nxi_reg <= s_data.dividend_im[31];
            nyr_reg <= s_data.divisor_re[31];
            nyi_reg <= s_data.divisor_im[31];
        end
        // one product per cycle, registered, then stored in the cycle after
        prod_reg <= op_a * op_b;
        if (state_reg == S_MUL && cnt_reg != 3'd0) begin
            pr_reg[cnt_reg - 3'd1] <= prod_reg;
        end
        if (state_reg == S_SUM) begin
            mod_reg <= pr_reg[0] + pr_reg[1];
        end
        if (state_reg == S_NUM && cnt_reg == 3'd0) begin
            nre_reg <= num_sum;
        end
        if (state_reg == S_NUM && cnt_reg == 3'd1) begin
            nim_reg <= num_sum;
        end
    end

    `CD_ASSERT_IMP(a_no_overlap, m_valid, !s_ready, "result pending while taking a request")
    `CD_ASSERT_NXT(a_busy_after_req, s_valid && s_ready, !s_ready, "ready after request")
    `CD_ASSERT_IMP(a_fault_zero, m_valid && m_data.divide_fault, m_data.quotient_re == 0 && m_data.quotient_im == 0 && !m_data.saturated, "fault result not zero")
    `CD_ASSERT_NXT(a_fcnt_mono, 1'b1, fcnt_reg >= $past(fcnt_reg), "fault count went down")

endmodule

/* dv/complex_divide_top_tb.sv */
// Testbench for complex_divide_top: drives dividend/divisor requests and
// checks each quotient, flag and fault count against an in-bench fixed-point divide model.
// Depends on cdiv_pkg and the complex_divide_top RTL.
module complex_divide_top_tb import cdiv_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QBITS = CDIV_FRAC_BITS;

    // Expected quotients, predicted from each accepted request.
    class quotient_board;
        cdiv_out_t   pending[$];
        logic [31:0] fault_count;
        int          errors;

        function new();
            fault_count = '0;
            errors = 0;
        endfunction

        // Split a 32-bit two's complement value into sign and magnitude.
        function automatic logic [63:0] to_mag(logic [31:0] v, output logic neg);
            neg = v[31];
            return {32'd0, (v[31] ? (32'd0 - v) : v)};
        endfunction

        // Add two sign/magnitude values.
        function automatic logic [63:0] signed_sum(logic na, logic [63:0] ma,
                                                   logic nb, logic [63:0] mb,
                                                   output logic neg);
            if (na == nb) begin
                neg = na;
                return ma + mb;
            end
            if (ma >= mb) begin
                neg = na;
                return ma - mb;
            end
            neg = nb;
            return mb - ma;
        endfunction

        // Shift the numerator up by the fraction bits, divide, clamp, re-sign.
        function automatic logic [31:0] scaled_quotient(logic neg, logic [63:0] num,
                                                        logic [63:0] den,
                                                        inout logic sat);
            logic [127:0] q;
            logic [63:0]  limit;
            q = ({64'd0, num} << QBITS) / {64'd0, den};
            limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            if (q > {64'd0, limit}) begin
                q = {64'd0, limit};
                sat = 1'b1;
            end
            return neg ? (32'd0 - q[31:0]) : q[31:0];
        endfunction

        function void note_request(cdiv_in_t d);
            cdiv_out_t   e;
            logic        nxr, nxi, nyr, nyi, nre, nim, sat;
            logic [63:0] xr, xi, yr, yi, modulus, mre, mim;
            xr = to_mag(d.dividend_re, nxr);
            xi = to_mag(d.dividend_im, nxi);
            yr = to_mag(d.divisor_re, nyr);
            yi = to_mag(d.divisor_im, nyi);
            modulus = yr * yr + yi * yi;
            e = '0;
            sat = 1'b0;
            if (modulus == 0) begin
                if (fault_count != 32'hFFFF_FFFF) fault_count++;
                e.divide_fault = 1'b1;
            end else begin
                mre = signed_sum(nxr ^ nyr, xr * yr, nxi ^ nyi, xi * yi, nre);
                mim = signed_sum(nxi ^ nyr, xi * yr, ~(nxr ^ nyi), xr * yi, nim);
                e.quotient_re = scaled_quotient(nre, mre, modulus, sat);
                e.quotient_im = scaled_quotient(nim, mim, modulus, sat);
                e.saturated = sat;
            end
            e.fault_total = fault_count;
            pending.push_back(e);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(cdiv_out_t g);
            cdiv_out_t e;
            if (pending.size() == 0) begin
                report("unexpected result", g.quotient_re, 32'd0);
                return;
            end
            e = pending.pop_front();
            if (g.quotient_re !== e.quotient_re) report("quotient_re", g.quotient_re, e.quotient_re);
            if (g.quotient_im !== e.quotient_im) report("quotient_im", g.quotient_im, e.quotient_im);
            if (g.divide_fault !== e.divide_fault)
                report("divide_fault", 32'(g.divide_fault), 32'(e.divide_fault));
            if (g.saturated !== e.saturated)
                report("saturated", 32'(g.saturated), 32'(e.saturated));
            if (g.fault_total !== e.fault_total) report("fault_total", g.fault_total, e.fault_total);
        endtask
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    cdiv_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    cdiv_out_t m_data;

    quotient_board board = new();
    bit            steady;   // no idling on either side while set

    complex_divide_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #1 aclk = ~aclk;

    // Note requests and check results at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) board.note_request(s_data);
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    // Stall the result side at random.
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 28);
    end

    // Pick an edge-heavy field value.
    function automatic logic [31:0] pick_part();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'h0100_0000;
            4: return 32'hFF00_0000;
            5: return $urandom_range(255) - 128;
            6: return 32'($signed($urandom_range(65535)) - 32768) <<< 12;
            default: return $urandom;
        endcase
    endfunction

    // Send one request, idling beforehand at random; valid drops only while idling.
    task automatic send(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
        if (!steady && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while (!steady && $urandom_range(99) < 28);
        end
        s_valid <= 1'b1;
        s_data  <= '{a, b, c, d};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        logic [31:0] y_re, y_im;
        steady = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extremes, zero divisor, real divisor, saturation.
        send(32'h0100_0000, 32'h0200_0000, 32'h0100_0000, 32'h0);
        send(32'h0100_0000, 32'h0100_0000, 32'h0, 32'h0);
        send(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
        send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0);
        send(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001);
        send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send(32'h8000_0000, 32'h0, 32'hFF00_0000, 32'h0);
        send(32'h8000_0000, 32'h0, 32'h0100_0000, 32'h0);
        send(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF);
        send(32'h0300_0000, 32'hFD00_0000, 32'h0, 32'hFF00_0000);
        send(32'h0, 32'h0, 32'h0100_0000, 32'h0100_0000);
        send(32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
        send(32'h1234_5678, 32'h8765_4321, 32'h0000_0010, 32'hFFFF_FFF0);

        // Random: mixed traffic with a burst without idling in the middle.
        for (int i = 0; i < 1500; i++) begin
            steady = (i >= 200 && i < 350);
            y_re = pick_part();
            y_im = ($urandom_range(3) == 0) ? 32'd0 : pick_part();
            if ($urandom_range(19) == 0) y_re = 32'd0;
            send(pick_part(), pick_part(), y_re, y_im);
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        wait (board.pending.size() == 0);
        repeat (100) @(posedge aclk);
        if (board.errors == 0) begin
            $display("complex_divide_top: match");
        end else begin
            $display("complex_divide_top: mismatch");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2_000_000;
        $display("complex_divide_top: mismatch");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+design
design/cdiv_pkg.sv
design/cdiv_divider.sv
design/complex_divide_top.sv
dv/complex_divide_top_tb.sv
